// ===== hw/rtl/cofa_pkg.sv =====
// Shared types, codes and constants for the CMOS option field access block.
package cofa_pkg;

	// Default widest option field that is accepted.
	localparam int MAX_FIELD_BITS_DEF = 32;

	// Fixed payload widths.
	localparam int ACTION_W = 3;
	localparam int BITPOS_W = 11;
	localparam int FLEN_W   = 6;
	localparam int KIND_W   = 2;
	localparam int WVAL_W   = 32;
	localparam int BYTE_W   = 8;
	localparam int RVAL_W   = 32;
	localparam int STATUS_W = 2;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DAT_W = 11;
	localparam int SUM_W    = 16;

	// Action codes.
	localparam logic [ACTION_W-1:0] ACT_RD_FIELD = 3'd0;
	localparam logic [ACTION_W-1:0] ACT_WR_FIELD = 3'd1;
	localparam logic [ACTION_W-1:0] ACT_RD_BYTE  = 3'd2;
	localparam logic [ACTION_W-1:0] ACT_WR_BYTE  = 3'd3;
	localparam logic [ACTION_W-1:0] ACT_CHECKSUM = 3'd4;
	localparam logic [ACTION_W-1:0] ACT_UPD_SUM  = 3'd5;

	// Field kinds that are rejected.
	localparam logic [KIND_W-1:0] KIND_RESERVED = 2'd1;
	localparam logic [KIND_W-1:0] KIND_STRING   = 2'd2;

	// Result status codes.
	localparam logic [STATUS_W-1:0] ST_OK          = 2'd0;
	localparam logic [STATUS_W-1:0] ST_UNSUPPORTED = 2'd1;
	localparam logic [STATUS_W-1:0] ST_NO_LAYOUT   = 2'd2;
	localparam logic [STATUS_W-1:0] ST_MISALIGNED  = 2'd3;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] CFG_PRESENT  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_START    = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_END      = 2'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_LOCATION = 2'd3;

	// Reset value of the checksum end bit offset.
	localparam logic [CFG_DAT_W-1:0] CFG_END_RST = 11'd7;

	typedef struct packed {
		logic [ACTION_W-1:0] action;
		logic [BITPOS_W-1:0] bit_position;
		logic [FLEN_W-1:0]   field_length;
		logic [KIND_W-1:0]   field_kind;
		logic [WVAL_W-1:0]   write_value;
		logic [BYTE_W-1:0]   byte_address;
		logic [BYTE_W-1:0]   byte_data;
	} item_t;

	typedef struct packed {
		logic [RVAL_W-1:0]   read_value;
		logic [STATUS_W-1:0] status;
	} res_t;

	typedef struct packed {
		logic                 present;
		logic [CFG_DAT_W-1:0] start_bit;
		logic [CFG_DAT_W-1:0] end_bit;
		logic [CFG_DAT_W-1:0] loc_bit;
	} cfg_t;

	typedef struct packed {
		logic              we;
		logic [BYTE_W-1:0] addr;
		logic [BYTE_W-1:0] wdata;
	} ram_req_t;

endpackage

// ===== hw/rtl/cofa_req_if.sv =====
// Request channel carrying one action and its operands.
interface cofa_req_if;
	import cofa_pkg::*;

	logic                valid;
	logic                ready;
	logic [ACTION_W-1:0] action;
	logic [BITPOS_W-1:0] bit_position;
	logic [FLEN_W-1:0]   field_length;
	logic [KIND_W-1:0]   field_kind;
	logic [WVAL_W-1:0]   write_value;
	logic [BYTE_W-1:0]   byte_address;
	logic [BYTE_W-1:0]   byte_data;

	modport source (
		output valid, action, bit_position, field_length, field_kind,
		output write_value, byte_address, byte_data,
		input  ready
	);
	modport sink (
		input  valid, action, bit_position, field_length, field_kind,
		input  write_value, byte_address, byte_data,
		output ready
	);
endinterface

// ===== hw/rtl/cofa_rsp_if.sv =====
// Response channel carrying one result value and its status.
interface cofa_rsp_if;
	import cofa_pkg::*;

	logic                valid;
	logic                ready;
	logic [RVAL_W-1:0]   read_value;
	logic [STATUS_W-1:0] status;

	modport source (output valid, read_value, status, input ready);
	modport sink (input valid, read_value, status, output ready);
endinterface

// ===== hw/rtl/cofa_cfg_if.sv =====
// Configuration write channel carrying a register index and write data.
interface cofa_cfg_if;
	import cofa_pkg::*;

	logic                 valid;
	logic                 ready;
	logic [CFG_IDX_W-1:0] index;
	logic [CFG_DAT_W-1:0] wdata;

	modport source (output valid, index, wdata, input ready);
	modport sink (input valid, index, wdata, output ready);
endinterface

// ===== hw/rtl/cofa_ram.sv =====
// 256-byte CMOS RAM with registered read and per-byte valid bits for reset clear.
module cofa_ram (
	input  logic              clk,
	input  logic              arst_n,
	input  cofa_pkg::ram_req_t req,
	output logic [7:0]        rdata
);
	import cofa_pkg::*;

	localparam int DEPTH = 1 << BYTE_W;

	logic [BYTE_W-1:0] mem [DEPTH];
	logic [DEPTH-1:0]  vld_q;
	logic [BYTE_W-1:0] rd_q;
	logic              rvld_q;

	// Storage array and read data register.
	always_ff @(posedge clk) begin
		if (req.we) begin
			mem[req.addr] <= req.wdata;
		end
		rd_q <= mem[req.addr];
	end

	// Valid bits: a byte never written since reset reads as zero.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q  <= '0;
			rvld_q <= 1'b0;
		end else begin
			if (req.we) begin
				vld_q[req.addr] <= 1'b1;
			end
			rvld_q <= vld_q[req.addr];
		end
	end

	assign rdata = rvld_q ? rd_q : '0;
endmodule

// ===== hw/rtl/cofa_ctrl.sv =====
// Sequencer and byte datapath that run field access and checksum walks over the RAM.
module cofa_ctrl #(
	parameter int MAX_FIELD_BITS = cofa_pkg::MAX_FIELD_BITS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  cofa_pkg::item_t   item,
	input  cofa_pkg::cfg_t    cfg,
	output logic              idle,
	input  logic              res_free,
	output logic              res_push,
	output cofa_pkg::res_t    res,
	output cofa_pkg::ram_req_t ram_req,
	input  logic [7:0]        ram_rdata
);
	import cofa_pkg::*;

	// Bytes a field can touch, and the widths that follow from that.
	localparam int NB = (MAX_FIELD_BITS + 14) / 8;
	localparam int AW = 8 * NB;
	localparam int RW = (AW > RVAL_W) ? AW : RVAL_W;
	localparam int CW = $clog2(NB + 1);

	localparam logic [3:0] S_IDLE     = 4'd0;
	localparam logic [3:0] S_RD_FIELD = 4'd1;
	localparam logic [3:0] S_RD_RES   = 4'd2;
	localparam logic [3:0] S_RMW_RD   = 4'd3;
	localparam logic [3:0] S_RMW_WR   = 4'd4;
	localparam logic [3:0] S_CHK      = 4'd5;
	localparam logic [3:0] S_SUM      = 4'd6;
	localparam logic [3:0] S_SUM_LAST = 4'd7;
	localparam logic [3:0] S_SUM_END  = 4'd8;
	localparam logic [3:0] S_ST_HI    = 4'd9;
	localparam logic [3:0] S_ST_LO    = 4'd10;
	localparam logic [3:0] S_RD_BYTE  = 4'd11;
	localparam logic [3:0] S_BYTE_RES = 4'd12;
	localparam logic [3:0] S_WR_BYTE  = 4'd13;
	localparam logic [3:0] S_DONE     = 4'd14;

	logic [3:0]          state_q, state_d;
	logic                pend_q, pend_d;
	logic [CW-1:0]       bcnt_q, bcnt_d;
	logic [ACTION_W-1:0] act_q, act_d;
	logic [BYTE_W-1:0]   addr_q, addr_d;
	logic [2:0]          off_q, off_d;
	logic [FLEN_W-1:0]   len_q, len_d;
	logic [AW-1:0]       acc_q, acc_d;
	logic [AW-1:0]       msk_q, msk_d;
	logic [SUM_W-1:0]    sum_q, sum_d;
	res_t                res_q, res_d;

	logic [STATUS_W-1:0] layout_st;
	logic [BYTE_W-1:0]   first_byte, end_byte, loc_byte;
	logic                rejected;
	logic [AW-1:0]       len_msk;
	logic [RW-1:0]       wval_sh;
	logic [RW-1:0]       acc_sh;
	logic [RVAL_W-1:0]   rd_msk;
	logic [SUM_W-1:0]    sum_add;

	// Checksum layout check and the byte addresses of its range.
	assign first_byte = cfg.start_bit[CFG_DAT_W-1:3];
	assign end_byte   = cfg.end_bit[CFG_DAT_W-1:3];
	assign loc_byte   = cfg.loc_bit[CFG_DAT_W-1:3];

	always_comb begin
		if (!cfg.present) begin
			layout_st = ST_NO_LAYOUT;
		end else if (cfg.start_bit[2:0] != 3'd0 || cfg.end_bit[2:0] != 3'd7 ||
			cfg.loc_bit[2:0] != 3'd0) begin
			layout_st = ST_MISALIGNED;
		end else begin
			layout_st = ST_OK;
		end
	end

	// Field admission and alignment of write data and mask to the first byte.
	assign rejected = (item.field_kind == KIND_RESERVED) ||
		(item.field_kind == KIND_STRING) ||
		({1'b0, item.field_length} > 7'(MAX_FIELD_BITS));

	always_comb begin
		for (int i = 0; i < AW; i++) begin
			len_msk[i] = (i < int'(item.field_length));
		end
		for (int i = 0; i < RVAL_W; i++) begin
			rd_msk[i] = (i < int'(len_q));
		end
	end

	assign wval_sh = RW'(item.write_value) << item.bit_position[2:0];
	assign acc_sh  = RW'(acc_q) >> off_q;
	assign sum_add = sum_q + SUM_W'(ram_rdata);

	// Next-state and datapath logic.
	always_comb begin
		state_d = state_q;
		pend_d  = pend_q;
		bcnt_d  = bcnt_q;
		act_d   = act_q;
		addr_d  = addr_q;
		off_d   = off_q;
		len_d   = len_q;
		acc_d   = acc_q;
		msk_d   = msk_q;
		sum_d   = sum_q;
		res_d   = res_q;
		ram_req.we    = 1'b0;
		ram_req.addr  = addr_q;
		ram_req.wdata = acc_q[7:0];
		res_push = 1'b0;

		unique case (state_q)
			S_IDLE: begin
				if (start) begin
					act_d  = item.action;
					addr_d = item.byte_address;
					res_d  = '{read_value: '0, status: ST_OK};
					off_d  = item.bit_position[2:0];
					len_d  = item.field_length;
					bcnt_d = '0;
					pend_d = 1'b0;
					unique case (item.action)
						ACT_RD_FIELD, ACT_WR_FIELD: begin
							addr_d = item.bit_position[BITPOS_W-1:3];
							msk_d  = len_msk << item.bit_position[2:0];
							acc_d  = wval_sh[AW-1:0] & (len_msk << item.bit_position[2:0]);
							if (rejected) begin
								res_d.status = ST_UNSUPPORTED;
								state_d = S_DONE;
							end else if (item.action == ACT_RD_FIELD) begin
								state_d = S_RD_FIELD;
							end else begin
								state_d = S_RMW_RD;
							end
						end
						ACT_RD_BYTE: state_d = S_RD_BYTE;
						ACT_WR_BYTE: begin
							acc_d   = AW'(item.byte_data);
							state_d = S_WR_BYTE;
						end
						ACT_CHECKSUM, ACT_UPD_SUM: state_d = S_CHK;
						default: state_d = S_DONE;
					endcase
				end
			end
			// Read every byte a field can touch, shifting each in from the top.
			S_RD_FIELD: begin
				if (pend_q) begin
					acc_d = {ram_rdata, acc_q[AW-1:8]};
				end
				if (bcnt_q == CW'(NB)) begin
					pend_d  = 1'b0;
					state_d = S_RD_RES;
				end else begin
					addr_d = addr_q + 8'd1;
					bcnt_d = bcnt_q + CW'(1);
					pend_d = 1'b1;
				end
			end
			S_RD_RES: begin
				res_d.read_value = acc_sh[RVAL_W-1:0] & rd_msk;
				state_d = S_DONE;
			end
			// Read-modify-write of each byte a field can touch, under the aligned field mask.
			S_RMW_RD: state_d = S_RMW_WR;
			S_RMW_WR: begin
				ram_req.we    = 1'b1;
				ram_req.wdata = (ram_rdata & ~msk_q[7:0]) | (acc_q[7:0] & msk_q[7:0]);
				acc_d  = acc_q >> 8;
				msk_d  = msk_q >> 8;
				addr_d = addr_q + 8'd1;
				bcnt_d = bcnt_q + CW'(1);
				state_d = (bcnt_q == CW'(NB - 1)) ? S_CHK : S_RMW_RD;
			end
			// Decide whether a checksum walk follows.
			S_CHK: begin
				sum_d  = '0;
				pend_d = 1'b0;
				addr_d = first_byte;
				if (act_q == ACT_WR_FIELD && layout_st != ST_OK) begin
					if (layout_st == ST_MISALIGNED) begin
						res_d.status = ST_MISALIGNED;
					end
					state_d = S_DONE;
				end else if (layout_st != ST_OK) begin
					res_d.status = layout_st;
					state_d = S_DONE;
				end else if (first_byte > end_byte) begin
					state_d = S_SUM_END;
				end else begin
					state_d = S_SUM;
				end
			end
			// Walk the covered bytes, one read issued and one added per cycle.
			S_SUM: begin
				if (pend_q) begin
					sum_d = sum_add;
				end
				pend_d = 1'b1;
				if (addr_q == end_byte) begin
					state_d = S_SUM_LAST;
				end else begin
					addr_d = addr_q + 8'd1;
				end
			end
			S_SUM_LAST: begin
				sum_d   = sum_add;
				pend_d  = 1'b0;
				state_d = S_SUM_END;
			end
			S_SUM_END: begin
				if (act_q == ACT_CHECKSUM) begin
					res_d.read_value = RVAL_W'(sum_q);
					state_d = S_DONE;
				end else begin
					addr_d  = loc_byte;
					state_d = S_ST_HI;
				end
			end
			// Store the checksum big-endian, wrapping past the top byte.
			S_ST_HI: begin
				ram_req.we    = 1'b1;
				ram_req.wdata = sum_q[15:8];
				addr_d  = addr_q + 8'd1;
				state_d = S_ST_LO;
			end
			S_ST_LO: begin
				ram_req.we    = 1'b1;
				ram_req.wdata = sum_q[7:0];
				state_d = S_DONE;
			end
			S_RD_BYTE: state_d = S_BYTE_RES;
			S_BYTE_RES: begin
				res_d.read_value = RVAL_W'(ram_rdata);
				state_d = S_DONE;
			end
			S_WR_BYTE: begin
				ram_req.we = 1'b1;
				state_d = S_DONE;
			end
			// Hand the result to the output register once it is free.
			S_DONE: begin
				if (res_free) begin
					res_push = 1'b1;
					state_d  = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	// Control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			pend_q  <= 1'b0;
			bcnt_q  <= '0;
		end else begin
			state_q <= state_d;
			pend_q  <= pend_d;
			bcnt_q  <= bcnt_d;
		end
	end

	// Datapath registers.
	always_ff @(posedge clk) begin
		act_q  <= act_d;
		addr_q <= addr_d;
		off_q  <= off_d;
		len_q  <= len_d;
		acc_q  <= acc_d;
		msk_q  <= msk_d;
		sum_q  <= sum_d;
		res_q  <= res_d;
	end

	assign idle = (state_q == S_IDLE);
	assign res  = res_q;
endmodule

// ===== hw/rtl/cmos_option_field_access.sv =====
// A field read or write walks NB = (MAX_FIELD_BITS+14)/8 bytes of the RAM, byte by byte.
// A field write then refreshes the checksum over N bytes when the checksum layout is valid.
// Checksum compute and update walk the same N bytes; an empty range skips the walk, and a
// layout error ends the action at once; N is at most 256, set by the 8-bit byte address.
// One transaction is in flight at a time; the next is taken once the result is registered.
// Reset clears the configuration to its defaults and marks every RAM byte as zero at once.
module cmos_option_field_access #(
	parameter int MAX_FIELD_BITS = cofa_pkg::MAX_FIELD_BITS_DEF
) (
	input logic       clk,
	input logic       arst_n,
	cofa_req_if.sink  req,
	cofa_rsp_if.source rsp,
	cofa_cfg_if.sink  cfg
);
	import cofa_pkg::*;

	cfg_t      cfg_q;
	item_t     item;
	res_t      res;
	ram_req_t  ram_req;
	logic [7:0] ram_rdata;
	logic      idle;
	logic      res_push;
	logic      res_free;
	logic      out_valid_q;
	res_t      out_q;

	// Configuration registers, always ready.
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '{present: 1'b0, start_bit: '0, end_bit: CFG_END_RST, loc_bit: '0};
		end else if (cfg.valid) begin
			unique case (cfg.index)
				CFG_PRESENT:  cfg_q.present   <= cfg.wdata[0];
				CFG_START:    cfg_q.start_bit <= cfg.wdata;
				CFG_END:      cfg_q.end_bit   <= cfg.wdata;
				CFG_LOCATION: cfg_q.loc_bit   <= cfg.wdata;
				default: ;
			endcase
		end
	end

	// Request transaction is accepted only while the sequencer is idle.
	assign req.ready = idle;
	assign item = '{action: req.action, bit_position: req.bit_position,
		field_length: req.field_length, field_kind: req.field_kind,
		write_value: req.write_value, byte_address: req.byte_address,
		byte_data: req.byte_data};

	cofa_ctrl #(
		.MAX_FIELD_BITS(MAX_FIELD_BITS)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (req.valid & req.ready),
		.item      (item),
		.cfg       (cfg_q),
		.idle      (idle),
		.res_free  (res_free),
		.res_push  (res_push),
		.res       (res),
		.ram_req   (ram_req),
		.ram_rdata (ram_rdata)
	);

	cofa_ram u_ram (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (ram_req),
		.rdata  (ram_rdata)
	);

	// Output register holding one result until the response transaction completes.
	assign res_free = !out_valid_q || rsp.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_push) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_push) begin
			out_q <= res;
		end
	end

	assign rsp.valid      = out_valid_q;
	assign rsp.read_value = out_q.read_value;
	assign rsp.status     = out_q.status;
endmodule
